// ===== hdl/c3f_pkg.sv =====
package c3f_pkg;

	localparam int PIX_W      = 32;
	localparam int COEF_W     = 16;
	localparam int KSIZE      = 3;
	localparam int SUM_SHIFT  = 4;
	localparam int VAL_W      = PIX_W - SUM_SHIFT;
	localparam int POS_W      = 6;
	localparam int DIM_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = KSIZE * COEF_W;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	localparam logic [CFG_DATA_W-1:0] COEF_TOP_RST = 48'h0001_0002_0001;
	localparam logic [CFG_DATA_W-1:0] COEF_MID_RST = 48'h0002_0004_0002;
	localparam logic [CFG_DATA_W-1:0] COEF_BOT_RST = 48'h0001_0002_0001;
	localparam logic [DIM_W-1:0]      WIDTH_RST    = 7'd16;
	localparam logic [DIM_W-1:0]      HEIGHT_RST   = 7'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_TOP = 3'd0,
		REG_COEF_MID = 3'd1,
		REG_COEF_BOT = 3'd2,
		REG_WIDTH    = 3'd3,
		REG_HEIGHT   = 3'd4
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	// one window column: element 0 is the oldest row, element KSIZE-1 the current row
	typedef logic [KSIZE-1:0][PIX_W-1:0]  col_t;
	typedef logic [KSIZE-1:0][COEF_W-1:0] kcol_t;

	typedef struct packed {
		logic shift;    // window advances by one column
		logic load_s2;  // product stage takes new values
		logic load_s3;  // column sum stage takes new values
	} cell_ctl_t;

endpackage

// ===== hdl/c3f_if.sv =====
interface c3f_pix_if;
	logic                       valid;
	logic                       ready;
	logic [c3f_pkg::PIX_W-1:0]  pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface c3f_res_if;
	logic                       valid;
	logic                       ready;
	logic [c3f_pkg::VAL_W-1:0]  filtered_value;
	logic [c3f_pkg::POS_W-1:0]  out_row;
	logic [c3f_pkg::POS_W-1:0]  out_col;
	logic                       frame_end;

	modport source (output valid, output filtered_value, output out_row, output out_col,
		output frame_end, input ready);
	modport sink (input valid, input filtered_value, input out_row, input out_col,
		input frame_end, output ready);
endinterface

interface c3f_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [c3f_pkg::CFG_IDX_W-1:0]   index;
	logic [c3f_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/c3f_line_buf.sv =====
module c3f_line_buf #(
	parameter int DEPTH = c3f_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  c3f_pkg::pix_t              wr_pixel,
	output c3f_pkg::pix_t              top,
	output c3f_pkg::pix_t              mid
);

	c3f_pkg::pix_t older_mem [DEPTH];
	c3f_pkg::pix_t newer_mem [DEPTH];
	c3f_pkg::pix_t top_q;
	c3f_pkg::pix_t mid_q;

	// read data holds until the next item is accepted, so mid_q is still the
	// value read for the item being written back
	always_ff @(posedge clk) begin
		if (rd_en) begin
			top_q <= older_mem[rd_addr];
			mid_q <= newer_mem[rd_addr];
		end
		if (wr_en) begin
			older_mem[wr_addr] <= mid_q;
			newer_mem[wr_addr] <= wr_pixel;
		end
	end

	assign top = top_q;
	assign mid = mid_q;

endmodule

// ===== hdl/c3f_cell.sv =====
module c3f_cell (
	input  logic                clk,
	input  c3f_pkg::cell_ctl_t  ctl,
	input  c3f_pkg::col_t       col_in,
	input  c3f_pkg::kcol_t      kcol,
	output c3f_pkg::col_t       col_out,
	output c3f_pkg::pix_t       col_sum
);

	c3f_pkg::col_t col_q;
	c3f_pkg::pix_t prod_s2 [c3f_pkg::KSIZE];
	c3f_pkg::pix_t sum_s3;
	c3f_pkg::pix_t sum_next;

	always_comb begin
		sum_next = '0;
		for (int i = 0; i < c3f_pkg::KSIZE; i++) begin
			sum_next = sum_next + prod_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			col_q <= col_in;
		end
		if (ctl.load_s2) begin
			// keep the low word of each product: the sum wraps at the pixel width
			for (int i = 0; i < c3f_pkg::KSIZE; i++) begin
				prod_s2[i] <= c3f_pkg::pix_t'(col_in[i] * kcol[i]);
			end
		end
		if (ctl.load_s3) begin
			sum_s3 <= sum_next;
		end
	end

	assign col_out = col_q;
	assign col_sum = sum_s3;

endmodule

// ===== hdl/conv3x3_image_filter.sv =====
// 3x3 convolution over a row-major pixel stream.
// pixels: one 32-bit pixel per item; frames follow each other with no gap.
// results: one item per full 3x3 neighborhood, (height-2) x (width-2) per
//   frame, carrying the weighted sum (wrapped to 32 bits, shifted right by 4),
//   its output row and column, and frame_end on the last one of a frame.
// cfg: writes coefficient rows (index 0..2) and image width/height (3, 4);
//   always ready. A width or height write restarts the frame at row 0, col 0.
//   Write only while no item is in flight.
// Throughput: one pixel per clock until a stall on results fills every stage. The window is a chain of three column
//   cells, each with its own three multipliers, so every column of the
//   neighborhood is worked on in parallel.
// Stages: line store read, products, column sums, total. A result is presented
//   once the pixel completing its window has passed through all of them.
// When results stalls, the pipeline keeps filling its empty stages; pixels.ready
//   drops only when every stage holds a result. Border pixels pass without
//   taking a result slot.
// Reset clears the counters, the pipeline valid bits and the registers to a
//   1-2-1 / 2-4-2 / 1-2-1 kernel on a 16 x 16 frame. Line stores are not cleared.
module conv3x3_image_filter #(
	parameter int MAX_WIDTH  = c3f_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = c3f_pkg::MAX_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	c3f_pix_if.sink    pixels,
	c3f_res_if.source  results,
	c3f_cfg_if.sink    cfg
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int KS = c3f_pkg::KSIZE;
	localparam int KW = c3f_pkg::COEF_W;

	// configuration registers
	logic [c3f_pkg::CFG_DATA_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;
	logic [c3f_pkg::DIM_W-1:0]      width_q, height_q;
	logic                           dim_wr;

	assign cfg.ready = 1'b1;
	assign dim_wr = cfg.valid && (cfg.index == c3f_pkg::REG_WIDTH ||
		cfg.index == c3f_pkg::REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q <= c3f_pkg::COEF_TOP_RST;
			coef_mid_q <= c3f_pkg::COEF_MID_RST;
			coef_bot_q <= c3f_pkg::COEF_BOT_RST;
			width_q    <= c3f_pkg::WIDTH_RST;
			height_q   <= c3f_pkg::HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				c3f_pkg::REG_COEF_TOP: coef_top_q <= cfg.data;
				c3f_pkg::REG_COEF_MID: coef_mid_q <= cfg.data;
				c3f_pkg::REG_COEF_BOT: coef_bot_q <= cfg.data;
				c3f_pkg::REG_WIDTH:    width_q    <= cfg.data[c3f_pkg::DIM_W-1:0];
				c3f_pkg::REG_HEIGHT:   height_q   <= cfg.data[c3f_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// last column and last row, with the dimensions clamped to 3..MAX
	logic [31:0]   wdim32, hdim32, wlast32, hlast32;
	logic [CW-1:0] wlast;
	logic [RW-1:0] hlast;

	always_comb begin
		wdim32 = 32'(width_q);
		hdim32 = 32'(height_q);
		if (wdim32 < 32'(KS))
			wlast32 = 32'(KS - 1);
		else if (wdim32 > 32'(MAX_WIDTH))
			wlast32 = 32'(MAX_WIDTH - 1);
		else
			wlast32 = wdim32 - 32'd1;
		if (hdim32 < 32'(KS))
			hlast32 = 32'(KS - 1);
		else if (hdim32 > 32'(MAX_HEIGHT))
			hlast32 = 32'(MAX_HEIGHT - 1);
		else
			hlast32 = hdim32 - 32'd1;
	end

	assign wlast = wlast32[CW-1:0];
	assign hlast = hlast32[RW-1:0];

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic emit_s1;
	logic en2, en3, en4, lv1, accept;

	assign en4    = !v_s4 || results.ready;
	assign en3    = !v_s3 || en4;
	assign en2    = !v_s2 || en3;
	// a border pixel leaves stage 1 at once; it only feeds the window and line stores
	assign lv1    = v_s1 && (!emit_s1 || en2);
	assign pixels.ready = !v_s1 || lv1;
	assign accept = pixels.valid && pixels.ready;

	// position of the next pixel
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (dim_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == wlast) begin
				col_q <= '0;
				row_q <= (row_q == hlast) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (pixels.ready) v_s1 <= pixels.valid;
			if (en2)          v_s2 <= v_s1 && emit_s1;
			if (en3)          v_s3 <= v_s2;
			if (en4)          v_s4 <= v_s3;
		end
	end

	// stage 1 payload
	c3f_pkg::pix_t               px_s1;
	logic [CW-1:0]               col_s1;
	logic                        fe_s1;
	logic [c3f_pkg::POS_W-1:0]   orow_s1, ocol_s1;
	logic [31:0]                 orow32, ocol32;

	assign orow32 = 32'(row_q) - 32'(KS - 1);
	assign ocol32 = 32'(col_q) - 32'(KS - 1);

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixels.pixel;
			col_s1  <= col_q;
			emit_s1 <= (32'(row_q) >= 32'(KS - 1)) && (32'(col_q) >= 32'(KS - 1));
			fe_s1   <= (row_q == hlast) && (col_q == wlast);
			orow_s1 <= orow32[c3f_pkg::POS_W-1:0];
			ocol_s1 <= ocol32[c3f_pkg::POS_W-1:0];
		end
	end

	c3f_pkg::pix_t top_s1, mid_s1;

	c3f_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (col_q),
		.wr_en    (lv1),
		.wr_addr  (col_s1),
		.wr_pixel (px_s1),
		.top      (top_s1),
		.mid      (mid_s1)
	);

	// window: chain[0] is the current column, chain[g] the column g places back
	c3f_pkg::col_t      chain [KS];
	c3f_pkg::pix_t      csum  [KS];
	c3f_pkg::cell_ctl_t cell_ctl;

	assign chain[0][0] = top_s1;
	assign chain[0][1] = mid_s1;
	assign chain[0][2] = px_s1;

	assign cell_ctl.shift   = lv1;
	assign cell_ctl.load_s2 = en2;
	assign cell_ctl.load_s3 = en3;

	for (genvar g = 0; g < KS; g++) begin : g_cell
		localparam int J = KS - 1 - g;
		c3f_pkg::kcol_t kcol;

		assign kcol[0] = coef_top_q[J*KW +: KW];
		assign kcol[1] = coef_mid_q[J*KW +: KW];
		assign kcol[2] = coef_bot_q[J*KW +: KW];

		if (g < KS - 1) begin : g_link
			c3f_cell u_cell (
				.clk     (clk),
				.ctl     (cell_ctl),
				.col_in  (chain[g]),
				.kcol    (kcol),
				.col_out (chain[g+1]),
				.col_sum (csum[g])
			);
		end else begin : g_last
			c3f_cell u_cell (
				.clk     (clk),
				.ctl     (cell_ctl),
				.col_in  (chain[g]),
				.kcol    (kcol),
				.col_out (),
				.col_sum (csum[g])
			);
		end
	end

	// position and frame mark travel beside the arithmetic
	logic [c3f_pkg::POS_W-1:0] orow_s2, ocol_s2, orow_s3, ocol_s3, orow_s4, ocol_s4;
	logic                      fe_s2, fe_s3, fe_s4;
	logic [c3f_pkg::VAL_W-1:0] val_s4;
	c3f_pkg::pix_t             total;

	always_comb begin
		total = '0;
		for (int i = 0; i < KS; i++) begin
			total = total + csum[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
			fe_s2   <= fe_s1;
		end
		if (en3) begin
			orow_s3 <= orow_s2;
			ocol_s3 <= ocol_s2;
			fe_s3   <= fe_s2;
		end
		if (en4) begin
			orow_s4 <= orow_s3;
			ocol_s4 <= ocol_s3;
			fe_s4   <= fe_s3;
			val_s4  <= total[c3f_pkg::PIX_W-1:c3f_pkg::SUM_SHIFT];
		end
	end

	assign results.valid          = v_s4;
	assign results.filtered_value = val_s4;
	assign results.out_row        = orow_s4;
	assign results.out_col        = ocol_s4;
	assign results.frame_end      = fe_s4;

endmodule

// ===== hdl/c3f_checker.sv =====
module c3f_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [c3f_pkg::VAL_W-1:0]     filtered_value,
	input logic [c3f_pkg::POS_W-1:0]     out_row,
	input logic [c3f_pkg::POS_W-1:0]     out_col,
	input logic                          frame_end,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [c3f_pkg::CFG_IDX_W-1:0] cfg_index
);

	logic                      have_prev_q;
	logic                      prev_end_q;
	logic [c3f_pkg::POS_W-1:0] prev_row_q, prev_col_q;
	logic                      restart;

	assign restart = cfg_valid && cfg_ready && (cfg_index == c3f_pkg::REG_WIDTH ||
		cfg_index == c3f_pkg::REG_HEIGHT);

	// track the last delivered result; a dimension write starts a new frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_end_q  <= 1'b0;
			prev_row_q  <= '0;
			prev_col_q  <= '0;
		end else if (restart) begin
			have_prev_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			have_prev_q <= 1'b1;
			prev_end_q  <= frame_end;
			prev_row_q  <= out_row;
			prev_col_q  <= out_col;
		end
	end

	a_quiet_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered_value) &&
		$stable(out_row) && $stable(out_col) && $stable(frame_end))
		else $error("stalled result changed");

	a_ready_only_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked without output backpressure");

	a_raster_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && have_prev_q |->
		(prev_end_q && out_row == '0 && out_col == '0) ||
		(!prev_end_q && out_row == prev_row_q && out_col == prev_col_q + 6'd1) ||
		(!prev_end_q && out_col == '0 && out_row == prev_row_q + 6'd1))
		else $error("result out of raster order");

endmodule

bind conv3x3_image_filter c3f_checker u_c3f_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (pixels.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.filtered_value (results.filtered_value),
	.out_row        (results.out_row),
	.out_col        (results.out_col),
	.frame_end      (results.frame_end),
	.cfg_valid      (cfg.valid),
	.cfg_ready      (cfg.ready),
	.cfg_index      (cfg.index)
);
